// ----- src/assert_macros.svh -----
// assertion macros used by the allocator back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every edge outside reset
`define CHECK_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked on the next edge
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- src/scba_pkg.sv -----
// shared types and constants of the size class block allocator
package scba_pkg;
  localparam int GRANULE_BYTES_DEF = 8;
  localparam int NUM_CLASSES_DEF = 16;
  localparam int BLOCK_GRANULES_DEF = 4096;
  localparam int POOL_BLOCKS_DEF = 16;

  localparam int LINK_DEPTH = 65536;
  localparam logic [16:0] AVAIL_MAX = 17'h1ffff;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_LARGE = 2'd2,
    ST_OOM   = 2'd3
  } status_t;

  localparam logic [0:0] REG_MAX_BLOCKS = 1'b0;

  // classified request handed from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic        early;   // result already known in front
    status_t     status;
    logic [7:0]  ci;      // class index, zero based
    logic [15:0] granule;
    logic        qvalid;
  } job_t;
endpackage

// ----- src/scba_if.sv -----
// valid/ready channel interfaces for requests and results
interface scba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] size_bytes;
  logic [18:0] free_addr;
  logic [4:0]  query_class;
  modport source (output valid, cmd, size_bytes, free_addr, query_class, input ready);
  modport sink (input valid, cmd, size_bytes, free_addr, query_class, output ready);
endinterface

interface scba_rsp_if;
  logic        valid;
  logic        ready;
  logic [18:0] alloc_addr;
  logic [1:0]  status;
  logic [31:0] get_count;
  logic [31:0] free_count;
  logic [16:0] avail_count;
  modport source (output valid, alloc_addr, status, get_count, free_count, avail_count,
                  input ready);
  modport sink (input valid, alloc_addr, status, get_count, free_count, avail_count,
                output ready);
endinterface

// ----- src/scba_front.sv -----
// request classifier and two-entry job queue
module scba_front #(
  parameter int GRANULE_BYTES = scba_pkg::GRANULE_BYTES_DEF,
  parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  scba_req_if.sink       req,
  output logic           job_valid,
  input  logic           job_ready,
  output scba_pkg::job_t job
);
  localparam int GSH = $clog2(GRANULE_BYTES);
  localparam logic [16:0] MAX_SIZE = 17'(NUM_CLASSES * GRANULE_BYTES);

  scba_pkg::job_t q [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  scba_pkg::job_t cj;
  logic [15:0] sm1;
  logic [18:0] gidx;

  always_comb begin
    cj = '0;
    cj.cmd = scba_pkg::cmd_t'(req.cmd);
    sm1 = req.size_bytes - 16'd1;
    // granule size is a power of two
    gidx = 19'(req.free_addr >> GSH);
    cj.ci = 8'(sm1 >> GSH);
    cj.granule = gidx[15:0];
    cj.qvalid = (req.query_class >= 5'd1) && (32'(req.query_class) <= NUM_CLASSES);
    if (cj.cmd == scba_pkg::CMD_QUERY) begin
      if (req.query_class == 5'd0) cj.ci = '0;
      else cj.ci = 8'(req.query_class - 5'd1);
    end
    case (cj.cmd)
      scba_pkg::CMD_ALLOC, scba_pkg::CMD_FREE: begin
        if (req.size_bytes == 16'd0) begin
          cj.early = 1'b1; cj.status = scba_pkg::ST_ZERO;
        end else if ({1'b0, req.size_bytes} > MAX_SIZE) begin
          cj.early = 1'b1; cj.status = scba_pkg::ST_LARGE;
        end
      end
      scba_pkg::CMD_QUERY: cj.early = 1'b0;
      default: cj.early = 1'b1;
    endcase
  end

  assign req.ready = (count != 2'd2);
  assign job_valid = (count != 2'd0);
  assign job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) q[wr_ptr] <= cj;
    if (rst) begin
      count <= '0; rd_ptr <= 1'b0; wr_ptr <= 1'b0;
    end else begin
      if (req.valid && req.ready) wr_ptr <= ~wr_ptr;
      if (job_valid && job_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'((req.valid && req.ready) ? 1 : 0)
                     - 2'((job_valid && job_ready) ? 1 : 0);
    end
  end
endmodule

// ----- src/scba_back.sv -----
// list, bump and counter engine with result register
module scba_back #(
  parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF,
  parameter int GRANULE_BYTES = scba_pkg::GRANULE_BYTES_DEF,
  parameter int BLOCK_GRANULES = scba_pkg::BLOCK_GRANULES_DEF,
  parameter int POOL_BLOCKS = scba_pkg::POOL_BLOCKS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [4:0]     max_blocks,
  input  logic           job_valid,
  output logic           job_ready,
  input  scba_pkg::job_t job,
  scba_rsp_if.source     rsp
);
  `include "assert_macros.svh"
  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [15:0] class_head  [NUM_CLASSES];
  logic [16:0] class_avail [NUM_CLASSES];
  logic [31:0] class_gets  [NUM_CLASSES];
  logic [31:0] class_frees [NUM_CLASSES];
  logic [15:0] link_store  [scba_pkg::LINK_DEPTH];

  logic [16:0] bump_granule;
  logic [16:0] granules_left;
  logic        block_open;
  logic [8:0]  blocks_used;

  typedef enum logic [1:0] {S_RUN = 2'b01, S_POP = 2'b10} state_t;
  state_t state;

  logic [15:0] link_q;
  logic [CW-1:0] pci;
  logic [CW-1:0] ci;
  assign ci = job.ci[CW-1:0];

  logic [8:0]  limit;
  logic [16:0] cls;
  logic [16:0] new_base;
  logic [CW-1:0] left_ci;
  assign limit = (max_blocks < 5'(POOL_BLOCKS > 31 ? 31 : POOL_BLOCKS) ||
                  POOL_BLOCKS > 31) ? 9'(max_blocks) : 9'(POOL_BLOCKS);
  assign cls = 17'(ci) + 17'd1;
  assign new_base = 17'(blocks_used) * 17'(BLOCK_GRANULES);
  assign left_ci = CW'(granules_left - 17'd1);

  logic out_free;
  assign out_free = !rsp.valid || rsp.ready;
  assign job_ready = (state == S_RUN) && out_free;

  always_ff @(posedge clk) begin
    link_q <= link_store[class_head[ci]];
    if (job_valid && job_ready) begin
      rsp.alloc_addr <= '0; rsp.status <= job.status;
      rsp.get_count <= '0; rsp.free_count <= '0; rsp.avail_count <= '0;
      if (!job.early) begin
        case (job.cmd)
          scba_pkg::CMD_FREE: begin
            if (class_avail[ci] != scba_pkg::AVAIL_MAX) begin
              link_store[job.granule] <= class_head[ci];
              class_head[ci] <= job.granule;
            end
          end
          scba_pkg::CMD_QUERY: if (job.qvalid) begin
            rsp.get_count <= class_gets[ci];
            rsp.free_count <= class_frees[ci];
            rsp.avail_count <= class_avail[ci];
          end
          scba_pkg::CMD_ALLOC: begin
            if (class_avail[ci] != 17'd0) begin
              rsp.alloc_addr <= 19'(32'(class_head[ci]) * GRANULE_BYTES);
            end else if (block_open && granules_left >= cls) begin
              rsp.alloc_addr <= 19'(32'(bump_granule) * GRANULE_BYTES);
            end else if (blocks_used >= limit) begin
              rsp.status <= scba_pkg::ST_OOM;
            end else begin
              if (block_open && granules_left != 17'd0 &&
                  class_avail[left_ci] != scba_pkg::AVAIL_MAX) begin
                link_store[bump_granule[15:0]] <= class_head[left_ci];
                class_head[left_ci] <= bump_granule[15:0];
              end
              rsp.alloc_addr <= 19'(32'(new_base) * GRANULE_BYTES);
            end
          end
          default: ;
        endcase
      end
    end
    if (state == S_POP) class_head[pci] <= link_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN; rsp.valid <= 1'b0;
      bump_granule <= '0; granules_left <= '0; block_open <= 1'b0; blocks_used <= '0;
      pci <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_avail[i] <= '0; class_gets[i] <= '0; class_frees[i] <= '0;
      end
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      if (state == S_POP) state <= S_RUN;
      if (job_valid && job_ready) begin
        rsp.valid <= 1'b1;
        if (!job.early) begin
          case (job.cmd)
            scba_pkg::CMD_FREE: begin
              class_frees[ci] <= class_frees[ci] + 32'd1;
              if (class_avail[ci] != scba_pkg::AVAIL_MAX)
                class_avail[ci] <= class_avail[ci] + 17'd1;
            end
            scba_pkg::CMD_ALLOC: begin
              if (class_avail[ci] != 17'd0) begin
                // head advances next cycle from the registered link read
                class_avail[ci] <= class_avail[ci] - 17'd1;
                class_gets[ci] <= class_gets[ci] + 32'd1;
                pci <= ci; state <= S_POP;
              end else if (block_open && granules_left >= cls) begin
                bump_granule <= bump_granule + cls;
                granules_left <= granules_left - cls;
                class_gets[ci] <= class_gets[ci] + 32'd1;
              end else if (blocks_used < limit) begin
                if (block_open && granules_left != 17'd0 &&
                    class_avail[left_ci] != scba_pkg::AVAIL_MAX)
                  class_avail[left_ci] <= class_avail[left_ci] + 17'd1;
                bump_granule <= new_base + cls;
                granules_left <= 17'(BLOCK_GRANULES) - cls;
                blocks_used <= blocks_used + 9'd1;
                block_open <= 1'b1;
                class_gets[ci] <= class_gets[ci] + 32'd1;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  `CHECK_NEXT(pop_one_cycle, clk, rst, state == S_POP, state == S_RUN,
              "pop step lasted more than one cycle")
  `CHECK_ALWAYS(blocks_bounded, clk, rst, blocks_used <= 9'(POOL_BLOCKS),
                "more blocks opened than the pool holds")
  `CHECK_NEXT(rsp_holds, clk, rst, rsp.valid && !rsp.ready, rsp.valid,
              "result dropped while stalled")
endmodule

// ----- src/size_class_block_allocator.sv -----
// top level of the size class block allocator
//   channel  dir  handshake
//   req      in   req.valid / req.ready
//   rsp      out  rsp.valid / rsp.ready
//   apb      in   psel, penable, pwrite (pready tied high)
// a request beat enters the two-job front queue; the back end takes it when
// neither a pop nor a waiting result stalls it, and registers its result beat.
// a free or query finishes in S_RUN; an allocate that takes a list head
// pops in S_POP: the link memory read is registered before the head update.
// while a result waits the front queue still takes up to two more request beats.
// reset is synchronous; link and head memories are not cleared.
module size_class_block_allocator #(
  parameter int GRANULE_BYTES = scba_pkg::GRANULE_BYTES_DEF,
  parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF,
  parameter int BLOCK_GRANULES = scba_pkg::BLOCK_GRANULES_DEF,
  parameter int POOL_BLOCKS = scba_pkg::POOL_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  scba_req_if.sink    req,
  scba_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [4:0] max_blocks;
  logic job_valid, job_ready;
  scba_pkg::job_t job;
  logic sel_max_blocks;

  assign pready = 1'b1;
  assign sel_max_blocks = (paddr == 2'(4 * scba_pkg::REG_MAX_BLOCKS));
  assign prdata = sel_max_blocks ? {27'd0, max_blocks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) max_blocks <= 5'd16;
    else if (psel && penable && pwrite && pready && sel_max_blocks) max_blocks <= pwdata[4:0];
  end

  scba_front #(.GRANULE_BYTES(GRANULE_BYTES), .NUM_CLASSES(NUM_CLASSES)) u_front (
    .clk, .rst, .req, .job_valid, .job_ready, .job);

  scba_back #(.NUM_CLASSES(NUM_CLASSES), .GRANULE_BYTES(GRANULE_BYTES),
              .BLOCK_GRANULES(BLOCK_GRANULES), .POOL_BLOCKS(POOL_BLOCKS)) u_back (
    .clk, .rst, .max_blocks, .job_valid, .job_ready, .job, .rsp);
endmodule
